/* hdl/fqsniff_pkg.sv */
// shared types, character codes and helpers for the fastq/sam block sniffer
// no dependencies; imported by every module of the block
package fqsniff_pkg;

  localparam longint BLOCK_BYTES = 64'd16777216;
  localparam logic [23:0] SAT_LIM =
    ((BLOCK_BYTES - 64'd1) > 64'hFF_FFFF) ? 24'hFF_FFFF : 24'(BLOCK_BYTES - 64'd1);

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [23:0] THRESH_RST = 24'd255;

  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_A  = 8'h41;
  localparam logic [7:0] CH_C  = 8'h43;
  localparam logic [7:0] CH_D  = 8'h44;
  localparam logic [7:0] CH_G  = 8'h47;
  localparam logic [7:0] CH_H  = 8'h48;
  localparam logic [7:0] CH_N  = 8'h4E;
  localparam logic [7:0] CH_O  = 8'h4F;
  localparam logic [7:0] CH_P  = 8'h50;
  localparam logic [7:0] CH_Q  = 8'h51;
  localparam logic [7:0] CH_R  = 8'h52;
  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] CH_T  = 8'h54;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LC = 8'h63;
  localparam logic [7:0] CH_LG = 8'h67;
  localparam logic [7:0] CH_LN = 8'h6E;
  localparam logic [7:0] CH_LT = 8'h74;

  // first and second letter of a sam header tag
  typedef enum logic [2:0] {
    C1_NONE, C1_H, C1_S, C1_R, C1_P, C1_C
  } c1_code_t;

  typedef enum logic [2:0] {
    C2_NONE, C2_D, C2_Q, C2_G, C2_O
  } c2_code_t;

  typedef enum logic [1:0] {
    VERD_BIN   = 2'd0,
    VERD_SAM   = 2'd1,
    VERD_SHORT = 2'd2,
    VERD_LONG  = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    PH_HEAD = 2'd0,
    PH_SEQ  = 2'd1,
    PH_SEP  = 2'd2,
    PH_QUAL = 2'd3
  } phase_t;

  // one classified word between front and back
  typedef struct packed {
    logic     is_nl;
    logic     is_at;
    logic     is_plus;
    logic     is_base;
    c1_code_t c1;
    c2_code_t c2;
    logic     start;
    logic     last;
    logic     first;
    logic     cont;
  } qitem_t;

  function automatic logic [23:0] sat_inc(input logic [23:0] v);
    sat_inc = (v < SAT_LIM) ? v + 24'd1 : SAT_LIM;
  endfunction

  function automatic logic sam_head(input c1_code_t a, input c2_code_t b);
    sam_head = (a == C1_H && b == C2_D) || (a == C1_S && b == C2_Q) ||
               (a == C1_R && b == C2_G) || (a == C1_P && b == C2_G) ||
               (a == C1_C && b == C2_O);
  endfunction

endpackage

/* hdl/fqsniff_front.sv */
// front end: takes input words and classifies each byte into a queue word
// depends on fqsniff_pkg
module fqsniff_front
  import fqsniff_pkg::*;
(
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_block_start,
  input  logic       in_block_end,
  input  logic       in_first_block,
  input  logic       in_continues_sam,
  input  logic       q_full,
  output logic       q_push,
  output qitem_t     q_item
);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item         = '0;
    q_item.is_nl   = (in_data_byte == CH_NL);
    q_item.is_at   = (in_data_byte == CH_AT);
    q_item.is_plus = (in_data_byte == CH_PLUS);
    q_item.start   = in_block_start;
    q_item.last    = in_block_end;
    q_item.first   = in_first_block;
    q_item.cont    = in_continues_sam;

    unique case (in_data_byte) inside
      CH_A, CH_C, CH_G, CH_T, CH_N, CH_LA, CH_LC, CH_LG, CH_LT, CH_LN:
        q_item.is_base = 1'b1;
      default: q_item.is_base = 1'b0;
    endcase

    unique case (in_data_byte)
      CH_H:    q_item.c1 = C1_H;
      CH_S:    q_item.c1 = C1_S;
      CH_R:    q_item.c1 = C1_R;
      CH_P:    q_item.c1 = C1_P;
      CH_C:    q_item.c1 = C1_C;
      default: q_item.c1 = C1_NONE;
    endcase

    unique case (in_data_byte)
      CH_D:    q_item.c2 = C2_D;
      CH_Q:    q_item.c2 = C2_Q;
      CH_G:    q_item.c2 = C2_G;
      CH_O:    q_item.c2 = C2_O;
      default: q_item.c2 = C2_NONE;
    endcase
  end

endmodule

/* hdl/fqsniff_queue.sv */
// short fifo of classified words between front and back
// depends on fqsniff_pkg
module fqsniff_queue
  import fqsniff_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  qitem_t push_item,
  input  logic   pop,
  output qitem_t head_item,
  output logic   nonempty,
  output logic   full
);

  qitem_t            mem [Q_DEPTH];
  logic [Q_AW-1:0]   wptr_r, wptr_nxt;
  logic [Q_AW-1:0]   rptr_r, rptr_nxt;
  logic [Q_AW:0]     cnt_r, cnt_nxt;

  assign nonempty  = (cnt_r != '0);
  assign full      = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign head_item = mem[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= push_item;
    end
  end

endmodule

/* hdl/fqsniff_back.sv */
// back end: per-block line checks, counters, verdict and the output register
// depends on fqsniff_pkg
module fqsniff_back
  import fqsniff_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data,
  input  qitem_t      q_item,
  input  logic        q_nonempty,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_newline_valid,
  output logic [23:0] out_newline_pos,
  output logic        out_verdict_valid,
  output logic [1:0]  out_verdict,
  output logic [23:0] out_max_seq_len
);

  logic [23:0] thresh_r;
  logic [23:0] off_r, off_nxt;
  logic [23:0] line_len_r, line_len_nxt;
  phase_t      phase_r, phase_nxt;
  logic [23:0] seq_len_r, seq_len_nxt;
  logic [23:0] longest_r, longest_nxt;
  c1_code_t    h1_r, h1_nxt;
  c2_code_t    h2_r, h2_nxt;
  logic        f_cont_r, f_cont_nxt;
  logic        f_first_r, f_first_nxt;
  logic        f_at_r, f_at_nxt;
  logic        f_fail_r, f_fail_nxt;
  logic        f_head_r, f_head_nxt;
  logic        fault_r, fault_nxt;

  logic        res;
  logic        nl_v;
  logic [23:0] nl_pos;
  verdict_t    verd;
  logic [23:0] maxlen;

  logic        ov_r;
  logic        onl_v_r;
  logic [23:0] onl_pos_r;
  logic        oend_r;
  verdict_t    overd_r;
  logic [23:0] omax_r;

  // room when the output register is empty or being taken
  assign q_pop = q_nonempty && (!ov_r || !out_stall);

  always_comb begin : p_step
    logic [23:0] pos;
    logic        sam;
    logic        bad;
    bad          = 1'b0;
    off_nxt      = off_r;
    line_len_nxt = line_len_r;
    phase_nxt    = phase_r;
    seq_len_nxt  = seq_len_r;
    longest_nxt  = longest_r;
    h1_nxt       = h1_r;
    h2_nxt       = h2_r;
    f_cont_nxt   = f_cont_r;
    f_first_nxt  = f_first_r;
    f_at_nxt     = f_at_r;
    f_fail_nxt   = f_fail_r;
    f_head_nxt   = f_head_r;
    fault_nxt    = fault_r;
    nl_v         = 1'b0;
    nl_pos       = '0;
    verd         = VERD_BIN;
    maxlen       = '0;

    // a byte with block_start set, or with no block open, starts one
    if (q_item.start || off_r == '0) begin
      off_nxt      = '0;
      line_len_nxt = '0;
      phase_nxt    = PH_HEAD;
      seq_len_nxt  = '0;
      longest_nxt  = '0;
      h1_nxt       = C1_NONE;
      h2_nxt       = C2_NONE;
      f_cont_nxt   = q_item.cont;
      f_first_nxt  = q_item.first;
      f_at_nxt     = 1'b0;
      f_fail_nxt   = 1'b0;
      f_head_nxt   = 1'b0;
      fault_nxt    = 1'b0;
    end
    pos = off_nxt;

    if (pos == 24'd0 && q_item.is_at) f_at_nxt = 1'b1;
    if (pos == 24'd1) h1_nxt = q_item.c1;
    if (pos == 24'd2) h2_nxt = q_item.c2;
    if (pos == 24'd3 && f_first_nxt && f_at_nxt && sam_head(h1_nxt, h2_nxt)) begin
      f_head_nxt = 1'b1;
    end
    sam = f_cont_nxt || f_head_nxt;

    if (q_item.is_nl) begin
      if (sam) begin
        nl_v = 1'b1;
      end else if (f_at_nxt && !f_fail_nxt) begin
        bad = fault_nxt;
        if (phase_nxt == PH_QUAL && line_len_nxt != seq_len_nxt) bad = 1'b1;
        if (phase_nxt == PH_SEQ) begin
          seq_len_nxt = line_len_nxt;
          if (line_len_nxt > longest_nxt) longest_nxt = line_len_nxt;
        end
        if (bad) f_fail_nxt = 1'b1;
        else nl_v = 1'b1;
      end
      phase_nxt    = phase_t'(phase_nxt + 2'd1);
      line_len_nxt = '0;
      fault_nxt    = 1'b0;
    end else begin
      if (phase_nxt == PH_HEAD && line_len_nxt == '0 && !q_item.is_at) fault_nxt = 1'b1;
      if (phase_nxt == PH_SEQ && !q_item.is_base) fault_nxt = 1'b1;
      if (phase_nxt == PH_SEP && line_len_nxt == '0 && !q_item.is_plus) fault_nxt = 1'b1;
      line_len_nxt = sat_inc(line_len_nxt);
    end
    if (nl_v) nl_pos = pos;
    off_nxt = sat_inc(off_nxt);

    if (q_item.last) begin
      if (sam) begin
        verd = VERD_SAM;
      end else if (f_at_nxt && !f_fail_nxt && longest_nxt != '0) begin
        verd   = (longest_nxt > thresh_r) ? VERD_LONG : VERD_SHORT;
        maxlen = longest_nxt;
      end
      off_nxt      = '0;
      line_len_nxt = '0;
      phase_nxt    = PH_HEAD;
      seq_len_nxt  = '0;
      longest_nxt  = '0;
      h1_nxt       = C1_NONE;
      h2_nxt       = C2_NONE;
      f_cont_nxt   = 1'b0;
      f_first_nxt  = 1'b0;
      f_at_nxt     = 1'b0;
      f_fail_nxt   = 1'b0;
      f_head_nxt   = 1'b0;
      fault_nxt    = 1'b0;
    end
  end

  assign res = nl_v || q_item.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r   <= THRESH_RST;
      off_r      <= '0;
      line_len_r <= '0;
      phase_r    <= PH_HEAD;
      seq_len_r  <= '0;
      longest_r  <= '0;
      h1_r       <= C1_NONE;
      h2_r       <= C2_NONE;
      f_cont_r   <= 1'b0;
      f_first_r  <= 1'b0;
      f_at_r     <= 1'b0;
      f_fail_r   <= 1'b0;
      f_head_r   <= 1'b0;
      fault_r    <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thresh_r <= cfg_wr_data;
      end
      if (q_pop) begin
        off_r      <= off_nxt;
        line_len_r <= line_len_nxt;
        phase_r    <= phase_nxt;
        seq_len_r  <= seq_len_nxt;
        longest_r  <= longest_nxt;
        h1_r       <= h1_nxt;
        h2_r       <= h2_nxt;
        f_cont_r   <= f_cont_nxt;
        f_first_r  <= f_first_nxt;
        f_at_r     <= f_at_nxt;
        f_fail_r   <= f_fail_nxt;
        f_head_r   <= f_head_nxt;
        fault_r    <= fault_nxt;
      end
      if (q_pop && res) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && res) begin
      onl_v_r   <= nl_v;
      onl_pos_r <= nl_pos;
      oend_r    <= q_item.last;
      overd_r   <= verd;
      omax_r    <= maxlen;
    end
  end

  assign out_valid         = ov_r;
  assign out_newline_valid = onl_v_r;
  assign out_newline_pos   = onl_pos_r;
  assign out_verdict_valid = oend_r;
  assign out_verdict       = overd_r;
  assign out_max_seq_len   = omax_r;

endmodule

/* hdl/fastq_sam_block_sniffer_top.sv */
// fastq/sam block sniffer: one byte per word, classifies each block.
// a result is registered: its byte is written to the queue, then the back end's
// step loads the output register. throughput: one byte per cycle while out_stall
// is low; a four-word queue lets front and back stall apart.
// reset (rst_n low, synchronous) empties the queue and output, clears the block
// state and sets the long-read threshold to 255.
module fastq_sam_block_sniffer_top
  import fqsniff_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_block_start,
  input  logic        in_block_end,
  input  logic        in_first_block,
  input  logic        in_continues_sam,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_newline_valid,
  output logic [23:0] out_newline_pos,
  output logic        out_verdict_valid,
  output logic [1:0]  out_verdict,
  output logic [23:0] out_max_seq_len
);

  qitem_t push_item;
  qitem_t head_item;
  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_nonempty;

  fqsniff_front u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_block_start   (in_block_start),
    .in_block_end     (in_block_end),
    .in_first_block   (in_first_block),
    .in_continues_sam (in_continues_sam),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_item           (push_item)
  );

  fqsniff_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .nonempty  (q_nonempty),
    .full      (q_full)
  );

  fqsniff_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .q_item            (head_item),
    .q_nonempty        (q_nonempty),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_newline_valid (out_newline_valid),
    .out_newline_pos   (out_newline_pos),
    .out_verdict_valid (out_verdict_valid),
    .out_verdict       (out_verdict),
    .out_max_seq_len   (out_max_seq_len)
  );

  // every result word carries a newline or a block end
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_newline_valid || out_verdict_valid))
    else $error("result word with neither newline nor verdict");

  // a length is only reported with a fastq verdict
  a_len_fastq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_max_seq_len != 24'd0) |->
      (out_verdict == VERD_SHORT || out_verdict == VERD_LONG))
    else $error("sequence length given without fastq verdict");

  // full queue cannot also be empty, and the front stalls exactly on full
  a_queue_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> (q_nonempty && in_stall && !q_push))
    else $error("queue full handling broken");

  // the back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_nonempty)
    else $error("pop from empty queue");

  // output register empty right after reset
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

/* tb/tb_fastq_sam_block_sniffer_top.sv */
// self-checking bench for fastq_sam_block_sniffer_top: directed table, then random blocks
// predicts newline reports and block verdicts in a behavioral shadow, but for fx rows
// depends on fqsniff_pkg and the top-level rtl only
module tb_fastq_sam_block_sniffer_top
  import fqsniff_pkg::*;
();

  localparam int LIMIT        = 300000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BYTES  = 175;
  localparam int DIR_ROWS     = 25;

  typedef struct packed {
    logic        nl;
    logic [23:0] pos;
    logic        vv;
    verdict_t    vd;
    logic [23:0] msl;
  } sniff_res_t;

  // fx marks rows whose result is typed in; en doubles as the typed verdict_valid
  typedef struct packed {
    logic [7:0]  b;
    logic        st;
    logic        en;
    logic        fb;
    logic        cs;
    logic        fx;
    logic        nl;
    logic [23:0] npos;
    verdict_t    vd;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [23:0] cfg_wr_data = 24'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_block_start = 1'b0;
  logic        in_block_end = 1'b0;
  logic        in_first_block = 1'b0;
  logic        in_continues_sam = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_newline_valid;
  logic [23:0] out_newline_pos;
  logic        out_verdict_valid;
  logic [1:0]  out_verdict;
  logic [23:0] out_max_seq_len;

  fastq_sam_block_sniffer_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_block_start    (in_block_start),
    .in_block_end      (in_block_end),
    .in_first_block    (in_first_block),
    .in_continues_sam  (in_continues_sam),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_newline_valid (out_newline_valid),
    .out_newline_pos   (out_newline_pos),
    .out_verdict_valid (out_verdict_valid),
    .out_verdict       (out_verdict),
    .out_max_seq_len   (out_max_seq_len)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dir_row_t dir_tab [DIR_ROWS] = '{
    // one-byte blocks: a plain byte, then one forced to sam by continuation
    '{8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 24'd0, VERD_BIN},
    '{8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 24'd0, VERD_SAM},
    // "@HD\n" as the first block of a file
    '{CH_AT, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 24'd0, VERD_BIN},
    '{CH_H,  1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 24'd0, VERD_BIN},
    '{CH_D,  1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 24'd0, VERD_BIN},
    '{CH_NL, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 24'd3, VERD_SAM},
    // "@CO" is one byte short of a sam header
    '{CH_AT, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 24'd0, VERD_BIN},
    '{CH_C,  1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 24'd0, VERD_BIN},
    '{CH_O,  1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 24'd0, VERD_BIN},
    // lower-case fastq record, opened without block_start
    '{CH_AT,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0, VERD_BIN},
    '{CH_NL,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0, VERD_BIN},
    '{CH_LG,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0, VERD_BIN},
    '{CH_LN,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0, VERD_BIN},
    '{CH_NL,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0, VERD_BIN},
    '{CH_PLUS, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0, VERD_BIN},
    '{CH_NL,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0, VERD_BIN},
    '{CH_LT,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0, VERD_BIN},
    '{CH_LA,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0, VERD_BIN},
    '{CH_NL,   1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0, VERD_BIN},
    // restart inside a block, then a sequence line with a bad byte
    '{CH_AT, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0, VERD_BIN},
    '{CH_AT, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0, VERD_BIN},
    '{CH_NL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0, VERD_BIN},
    '{CH_T,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0, VERD_BIN},
    '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0, VERD_BIN},
    '{CH_NL, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0, VERD_BIN}
  };

  // shadow of the sniffer state
  logic [23:0] sn_thr = THRESH_RST;
  logic [23:0] sn_ofs, sn_len, sn_seq, sn_top;
  phase_t      sn_line;
  logic [7:0]  sn_hb1, sn_hb2;
  logic        sn_cont, sn_first, sn_at, sn_fail, sn_head, sn_bad;

  sniff_res_t  pending_res[$];
  logic [7:0]  blk[$];
  int unsigned snd_idle = 0;
  int unsigned rcv_stall = 0;
  int          n_bytes = 0;
  int          n_bad = 0;
  int          n_nl = 0;
  int          n_verd [4] = '{0, 0, 0, 0};
  int          cycles = 0;
  sniff_res_t  mon_got, mon_want;

  function automatic void clear_block();
    sn_ofs = 24'd0;
    sn_len = 24'd0;
    sn_line = PH_HEAD;
    sn_seq = 24'd0;
    sn_top = 24'd0;
    sn_hb1 = 8'd0;
    sn_hb2 = 8'd0;
    {sn_cont, sn_first, sn_at, sn_fail, sn_head, sn_bad} = 6'd0;
  endfunction

  function automatic void blk_add(input logic [7:0] b);
    blk = {blk, b};
  endfunction

  function automatic logic nucleotide(input logic [7:0] b);
    return b == CH_A || b == CH_C || b == CH_G || b == CH_T || b == CH_N ||
           b == CH_LA || b == CH_LC || b == CH_LG || b == CH_LT || b == CH_LN;
  endfunction

  function automatic logic header_tag(input logic [7:0] a, input logic [7:0] b);
    return (a == CH_H && b == CH_D) || (a == CH_S && b == CH_Q) ||
           (a == CH_R && b == CH_G) || (a == CH_P && b == CH_G) ||
           (a == CH_C && b == CH_O);
  endfunction

  task automatic sniff_byte(input logic [7:0] b, input logic st, input logic en,
                            input logic fb, input logic cs,
                            output logic hit, output sniff_res_t r);
    logic [23:0] pos;
    logic        sam;
    logic        bad;
    r = '0;
    if (st || sn_ofs == 24'd0) begin
      clear_block();
      sn_cont = cs;
      sn_first = fb;
    end
    pos = sn_ofs;
    if (pos == 24'd0 && b == CH_AT) sn_at = 1'b1;
    if (pos == 24'd1) sn_hb1 = b;
    if (pos == 24'd2) sn_hb2 = b;
    if (pos == 24'd3 && sn_first && sn_at && header_tag(sn_hb1, sn_hb2)) sn_head = 1'b1;
    sam = sn_cont | sn_head;
    if (b == CH_NL) begin
      if (sam) begin
        r.nl = 1'b1;
      end else if (sn_at && !sn_fail) begin
        bad = sn_bad;
        if (sn_line == PH_QUAL && sn_len != sn_seq) bad = 1'b1;
        if (sn_line == PH_SEQ) begin
          sn_seq = sn_len;
          if (sn_len > sn_top) sn_top = sn_len;
        end
        if (bad) sn_fail = 1'b1;
        else r.nl = 1'b1;
      end
      sn_line = phase_t'(2'(sn_line + 2'd1));
      sn_len = 24'd0;
      sn_bad = 1'b0;
    end else begin
      if (sn_line == PH_HEAD && sn_len == 24'd0 && b != CH_AT) sn_bad = 1'b1;
      if (sn_line == PH_SEQ && !nucleotide(b)) sn_bad = 1'b1;
      if (sn_line == PH_SEP && sn_len == 24'd0 && b != CH_PLUS) sn_bad = 1'b1;
      if (sn_len != SAT_LIM) sn_len++;
    end
    if (r.nl) r.pos = pos;
    if (sn_ofs != SAT_LIM) sn_ofs++;
    if (en) begin
      r.vv = 1'b1;
      if (sam) begin
        r.vd = VERD_SAM;
      end else if (sn_at && !sn_fail && sn_top != 24'd0) begin
        r.vd = (sn_top > sn_thr) ? VERD_LONG : VERD_SHORT;
        r.msl = sn_top;
      end
      clear_block();
    end
    hit = r.nl | r.vv;
  endtask

  task automatic send_word(input logic [7:0] b, input logic st, input logic en,
                           input logic fb, input logic cs,
                           input logic fx, input sniff_res_t typed);
    logic       hit;
    sniff_res_t r;
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_block_start <= st;
    in_block_end <= en;
    in_first_block <= fb;
    in_continues_sam <= cs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_bytes++;
    sniff_byte(b, st, en, fb, cs, hit, r);
    if (fx) begin
      r = typed;
      hit = typed.nl | typed.vv;
    end
    if (hit) pending_res = {pending_res, r};
  endtask

  // hold the sender until every result is out and the pipe has emptied
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [23:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sn_thr = v;
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    return (b == CH_NL) ? CH_PLUS : b;
  endfunction

  function automatic logic [7:0] base_byte();
    case ($urandom_range(9))
      0: return CH_A;
      1: return CH_C;
      2: return CH_G;
      3: return CH_T;
      4: return CH_N;
      5: return CH_LA;
      6: return CH_LC;
      7: return CH_LG;
      8: return CH_LT;
      default: return CH_LN;
    endcase
  endfunction

  task automatic make_fastq(output logic fb, output logic cs);
    int slen;
    repeat ($urandom_range(1, 3)) begin
      slen = ($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
      blk_add(CH_AT);
      repeat ($urandom_range(0, 3)) blk_add(text_byte());
      blk_add(CH_NL);
      repeat (slen) blk_add(base_byte());
      blk_add(CH_NL);
      blk_add(CH_PLUS);
      repeat ($urandom_range(0, 2)) blk_add(text_byte());
      blk_add(CH_NL);
      repeat (slen) blk_add(text_byte());
      blk_add(CH_NL);
    end
    // trailing partial line, then the odd corrupted byte
    repeat ($urandom_range(0, 2)) blk_add(8'($urandom_range(255)));
    if ($urandom_range(3) == 0) blk[$urandom_range(blk.size() - 1)] = 8'($urandom_range(255));
    fb = 1'($urandom_range(1));
    cs = ($urandom_range(9) == 0);
  endtask

  task automatic make_sam(output logic fb, output logic cs);
    logic [7:0] c1, c2;
    int         k;
    k = $urandom_range(4);
    c1 = (k == 0) ? CH_H : (k == 1) ? CH_S : (k == 2) ? CH_R : (k == 3) ? CH_P : CH_C;
    c2 = (k == 0) ? CH_D : (k == 1) ? CH_Q : (k == 4) ? CH_O : CH_G;
    // near-miss tags fall through to the fastq checks
    if ($urandom_range(4) == 0) c2 = ($urandom_range(1) != 0) ? CH_Q : CH_O;
    cs = ($urandom_range(2) == 0);
    fb = cs ? 1'($urandom_range(1)) : ($urandom_range(5) != 0);
    blk_add(CH_AT);
    blk_add(c1);
    blk_add(c2);
    repeat ($urandom_range(1, 4)) begin
      repeat ($urandom_range(0, 6)) blk_add(text_byte());
      blk_add(CH_NL);
    end
  endtask

  task automatic make_noise(output logic fb, output logic cs);
    repeat ($urandom_range(1, 12))
      blk_add(($urandom_range(4) == 0) ? CH_NL : 8'($urandom_range(255)));
    fb = 1'($urandom_range(1));
    cs = 1'($urandom_range(1));
  endtask

  task automatic send_block(input logic fb, input logic cs);
    logic st_first, closed;
    int   i;
    st_first = ($urandom_range(9) != 0);
    closed = ($urandom_range(19) != 0);
    for (i = 0; i < blk.size(); i++)
      send_word(blk[i], (i == 0) ? st_first : ($urandom_range(99) == 0),
                closed && i == blk.size() - 1,
                (i == 0) ? fb : 1'($urandom_range(1)),
                (i == 0) ? cs : 1'($urandom_range(1)), 1'b0, '0);
    blk.delete();
  endtask

  always @(posedge clk) out_stall <= ($urandom_range(99) < rcv_stall);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending_res.size());
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      mon_got = '{out_newline_valid, out_newline_pos, out_verdict_valid,
                  verdict_t'(out_verdict), out_max_seq_len};
      if (pending_res.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected word: nl=%0b pos=%0d vv=%0b vd=%0d len=%0d", mon_got.nl,
                   mon_got.pos, mon_got.vv, mon_got.vd, mon_got.msl);
      end else begin
        mon_want = pending_res.pop_front();
        if (mon_got !== mon_want) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("mismatch at cycle %0d", cycles);
            $display("  expected nl=%0b pos=%0d vv=%0b vd=%0d len=%0d", mon_want.nl,
                     mon_want.pos, mon_want.vv, mon_want.vd, mon_want.msl);
            $display("  actual   nl=%0b pos=%0d vv=%0b vd=%0d len=%0d", mon_got.nl,
                     mon_got.pos, mon_got.vv, mon_got.vd, mon_got.msl);
          end
        end
        if (mon_want.nl) n_nl++;
        if (mon_want.vv) n_verd[mon_want.vd]++;
      end
    end
  end

  initial begin
    int          i, ph, mark;
    logic        held, fb, cs;
    logic [23:0] thr_tab [4];
    int unsigned snd_tab [4];
    int unsigned rcv_tab [4];
    sniff_res_t  typed;
    thr_tab = '{24'd0, 24'hFF_FFFF, 24'($urandom_range(2, 12)), 24'($urandom_range(4, 20))};
    snd_tab = '{0, 56, 0, 17};
    rcv_tab = '{0, 0, 56, 17};
    clear_block();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_ROWS; i++) begin
      typed = '{dir_tab[i].nl, dir_tab[i].npos, dir_tab[i].en, dir_tab[i].vd, 24'd0};
      send_word(dir_tab[i].b, dir_tab[i].st, dir_tab[i].en, dir_tab[i].fb,
                dir_tab[i].cs, dir_tab[i].fx, typed);
    end

    for (ph = 0; ph < 4; ph++) begin
      drain();
      set_threshold(thr_tab[ph]);
      snd_idle = snd_tab[ph];
      rcv_stall = rcv_tab[ph];
      mark = n_bytes;
      held = 1'b0;
      while (n_bytes - mark < PHASE_BYTES) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: make_fastq(fb, cs);
          6, 7: make_sam(fb, cs);
          default: make_noise(fb, cs);
        endcase
        send_block(fb, cs);
        if (!held && n_bytes - mark >= PHASE_BYTES / 2) begin
          drain();
          held = 1'b1;
        end
      end
    end

    drain();
    n_bad += pending_res.size();
    $display("streamed %0d bytes over four flow-control phases, thresholds 0 to %0d",
             n_bytes, 24'hFF_FFFF);
    $display("checked %0d newline reports; verdicts bin %0d sam %0d short %0d long %0d",
             n_nl, n_verd[VERD_BIN], n_verd[VERD_SAM], n_verd[VERD_SHORT], n_verd[VERD_LONG]);
    if (n_bad == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d errors", n_bad);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
